// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers included by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/icic_pkg.sv -----
package icic_pkg;

    localparam int CNT_W = 32;
    localparam int CMP_W = (CNT_W > 33) ? CNT_W : 33;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [31:0] CRC_POLY = 32'hedb88320;
    localparam logic [31:0] CRC_INIT = 32'hffffffff;
    localparam logic [31:0] TAG_IDAT = 32'h49444154;
    localparam logic [31:0] TAG_IEND = 32'h49454e44;

    localparam logic [2:0] FMT_PNG  = 3'd0;
    localparam logic [2:0] FMT_JPEG = 3'd1;
    localparam logic [2:0] FMT_GIF  = 3'd2;
    localparam logic [2:0] FMT_WEBP = 3'd3;

    localparam logic [7:0] JPEG_SOI1 = 8'hd8;
    localparam logic [15:0] JPEG_EOI = 16'hffd9;
    localparam logic [7:0] GIF_TRAIL = 8'h3b;

    typedef enum logic [5:0] {
        PH_SIG  = 6'b000001,
        PH_LEN  = 6'b000010,
        PH_TYPE = 6'b000100,
        PH_DATA = 6'b001000,
        PH_CRC  = 6'b010000,
        PH_DONE = 6'b100000
    } t_png_phase;

    typedef struct packed {
        logic       adv;   // item leaves the input register
        logic       upd;   // this tracker handles the format in force
        logic       last;
        logic [7:0] data;
    } t_step_ctl;

    typedef struct packed {
        logic failed;
        logic seen_iend;
    } t_png_status;

    typedef struct packed {
        logic [1:0]  header_match;
        logic [31:0] riff_size;
    } t_hdr_status;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [7:0] png_sig(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0: v = 8'h89;
            3'd1: v = 8'h50;
            3'd2: v = 8'h4e;
            3'd3: v = 8'h47;
            3'd4: v = 8'h0d;
            3'd5: v = 8'h0a;
            3'd6: v = 8'h1a;
            default: v = 8'h0a;
        endcase
        return v;
    endfunction

    // position 4 is checked separately ('7' or '9')
    function automatic logic [7:0] gif_head(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0: v = 8'h47;
            3'd1: v = 8'h49;
            3'd2: v = 8'h46;
            3'd3: v = 8'h38;
            3'd5: v = 8'h61;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] riff_tag(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0: v = 8'h52;
            2'd1: v = 8'h49;
            2'd2: v = 8'h46;
            default: v = 8'h46;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] webp_tag(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0: v = 8'h57;
            2'd1: v = 8'h45;
            2'd2: v = 8'h42;
            default: v = 8'h50;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/icic_png_tracker.sv -----
module icic_png_tracker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  icic_pkg::t_step_ctl   i_step,
    output icic_pkg::t_png_status o_status
);

    icic_pkg::t_png_phase r_phase, n_phase;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_size, n_size;
    logic [31:0] r_off, n_off;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_scrc, n_scrc;
    logic        r_idat, n_idat;
    logic        r_iend, n_iend;
    logic        r_failed, n_failed;
    logic [32:0] w_off_inc;
    logic [31:0] w_crc_upd;

    assign w_off_inc = {1'b0, r_off} + 33'd1;
    assign w_crc_upd = icic_pkg::crc_byte(r_crc, i_step.data);

    always_comb begin
        n_phase  = r_phase;
        n_crc    = r_crc;
        n_size   = r_size;
        n_off    = r_off;
        n_tag    = r_tag;
        n_scrc   = r_scrc;
        n_idat   = r_idat;
        n_iend   = r_iend;
        n_failed = r_failed;
        if (i_step.adv && i_step.upd) begin
            case (r_phase)
                icic_pkg::PH_SIG: begin
                    if (i_step.data != icic_pkg::png_sig(r_off[2:0])) n_failed = 1'b1;
                    n_off = w_off_inc[31:0];
                    if (w_off_inc >= 33'd8) begin
                        n_phase = icic_pkg::PH_LEN;
                        n_off   = '0;
                        n_size  = '0;
                    end
                end
                icic_pkg::PH_LEN: begin
                    n_size = {r_size[23:0], i_step.data};
                    n_off  = w_off_inc[31:0];
                    if (w_off_inc >= 33'd4) begin
                        n_phase = icic_pkg::PH_TYPE;
                        n_off   = '0;
                        n_crc   = icic_pkg::CRC_INIT;
                        n_tag   = '0;
                    end
                end
                icic_pkg::PH_TYPE: begin
                    n_crc = w_crc_upd;
                    n_tag = {r_tag[23:0], i_step.data};
                    n_off = w_off_inc[31:0];
                    if (w_off_inc >= 33'd4) begin
                        n_off   = '0;
                        n_scrc  = '0;
                        n_phase = (r_size != '0) ? icic_pkg::PH_DATA : icic_pkg::PH_CRC;
                    end
                end
                icic_pkg::PH_DATA: begin
                    n_crc = w_crc_upd;
                    n_off = w_off_inc[31:0];
                    if (w_off_inc >= {1'b0, r_size}) begin
                        n_phase = icic_pkg::PH_CRC;
                        n_off   = '0;
                    end
                end
                icic_pkg::PH_CRC: begin
                    n_scrc = {r_scrc[23:0], i_step.data};
                    n_off  = w_off_inc[31:0];
                    if (w_off_inc >= 33'd4) begin
                        n_off   = '0;
                        n_phase = icic_pkg::PH_LEN;
                        if (n_scrc != ~r_crc) begin
                            n_failed = 1'b1;
                        end else begin
                            if (r_tag == icic_pkg::TAG_IDAT) n_idat = 1'b1;
                            if (r_tag == icic_pkg::TAG_IEND) begin
                                if (r_size == '0 && n_idat) begin
                                    n_iend  = 1'b1;
                                    n_phase = icic_pkg::PH_DONE;
                                end else begin
                                    n_failed = 1'b1;
                                end
                            end else begin
                                n_size = '0;
                            end
                        end
                    end
                end
                default: n_failed = 1'b1;
            endcase
        end
    end

    assign o_status.failed    = n_failed;
    assign o_status.seen_iend = n_iend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.adv && i_step.last)) begin
            r_phase  <= icic_pkg::PH_SIG;
            r_crc    <= icic_pkg::CRC_INIT;
            r_size   <= '0;
            r_off    <= '0;
            r_tag    <= '0;
            r_scrc   <= '0;
            r_idat   <= 1'b0;
            r_iend   <= 1'b0;
            r_failed <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_crc    <= n_crc;
            r_size   <= n_size;
            r_off    <= n_off;
            r_tag    <= n_tag;
            r_scrc   <= n_scrc;
            r_idat   <= n_idat;
            r_iend   <= n_iend;
            r_failed <= n_failed;
        end
    end

endmodule

// ----- hw/rtl/icic_hdr_tracker.sv -----
module icic_hdr_tracker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  icic_pkg::t_step_ctl         i_step,
    input  logic [2:0]                  i_fmt,
    input  logic [icic_pkg::CNT_W-1:0]  i_pos,
    output icic_pkg::t_hdr_status       o_status
);

    logic [1:0]  r_match, n_match;
    logic [31:0] r_riff, n_riff;
    logic [7:0]  w_b;

    assign w_b = i_step.data;

    always_comb begin
        n_match = r_match;
        n_riff  = r_riff;
        if (i_step.adv && i_step.upd) begin
            case (i_fmt)
                icic_pkg::FMT_JPEG: begin
                    if ((i_pos == icic_pkg::CNT_W'(0) && w_b != 8'hff) ||
                        (i_pos == icic_pkg::CNT_W'(1) && w_b != icic_pkg::JPEG_SOI1))
                        n_match = r_match & 2'b10;
                end
                icic_pkg::FMT_GIF: begin
                    if (i_pos == icic_pkg::CNT_W'(4)) begin
                        n_match = r_match;
                        if (w_b != 8'h37) n_match[0] = 1'b0;
                        if (w_b != 8'h39) n_match[1] = 1'b0;
                    end else if (i_pos < icic_pkg::CNT_W'(6) &&
                                 w_b != icic_pkg::gif_head(i_pos[2:0])) begin
                        n_match = 2'b00;
                    end
                end
                icic_pkg::FMT_WEBP: begin
                    if (i_pos < icic_pkg::CNT_W'(4)) begin
                        if (w_b != icic_pkg::riff_tag(i_pos[1:0])) n_match = r_match & 2'b10;
                    end else if (i_pos < icic_pkg::CNT_W'(8)) begin
                        case (i_pos[1:0])
                            2'd0: n_riff[7:0]   = r_riff[7:0] | w_b;
                            2'd1: n_riff[15:8]  = r_riff[15:8] | w_b;
                            2'd2: n_riff[23:16] = r_riff[23:16] | w_b;
                            default: n_riff[31:24] = r_riff[31:24] | w_b;
                        endcase
                    end else if (i_pos < icic_pkg::CNT_W'(12)) begin
                        if (w_b != icic_pkg::webp_tag(i_pos[1:0])) n_match = r_match & 2'b01;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_status.header_match = n_match;
    assign o_status.riff_size    = n_riff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.adv && i_step.last)) begin
            r_match <= 2'b11;
            r_riff  <= '0;
        end else begin
            r_match <= n_match;
            r_riff  <= n_riff;
        end
    end

endmodule

// ----- hw/rtl/image_container_integrity_check_core.sv -----
// Image container integrity checker.
// Slave stream (i_s_*): one file byte per transfer, tlast on the final byte.
// Master stream (o_m_*): one verdict per file, sent for the final byte only.
// Config: i_cfg_wr_en / i_cfg_wr_data selects the format (0 png, 1 jpeg,
// 2 gif, 3 webp, other codes pass unless the byte count saturates); write it between files.
// Flow: a byte sits in the input register while the CRC step and trackers
// evaluate it; the verdict is registered in the output register when the
// final byte leaves the input register.
// Throughput: one byte per cycle, bounded by the one-byte CRC-32 update, save for the stall below.
// Back pressure: bytes keep flowing while a verdict waits; a final byte holds
// in the input register until the output register is free, and the slave
// side stalls until then.
// Reset: synchronous active-low i_rst_n clears all tracking state, empties
// both registers and sets the format to png. After each verdict the trackers
// and byte count return to their reset state; the format is kept.
module image_container_integrity_check_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [2:0] i_cfg_wr_data,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,   // last_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [0] intact, [7:1] zero
);

    `include "assert_macros.svh"

    logic [2:0]                 r_fmt;
    logic                       r_in_valid;
    logic                       r_in_last;
    logic [7:0]                 r_in_data;
    logic                       r_out_valid;
    logic                       r_out_intact;
    logic [icic_pkg::CNT_W-1:0] r_byte_count, n_byte_count;
    logic [15:0]                r_recent, n_recent;

    logic w_out_free;
    logic w_fire;
    logic w_ok;

    icic_pkg::t_step_ctl   w_png_step, w_hdr_step;
    icic_pkg::t_png_status w_png_st;
    icic_pkg::t_hdr_status w_hdr_st;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_fire     = r_in_valid && (!r_in_last || w_out_free);
    assign o_s_tready = !r_in_valid || w_fire;

    assign n_byte_count = (r_byte_count != icic_pkg::CNT_MAX) ?
                          r_byte_count + icic_pkg::CNT_W'(1) : r_byte_count;
    assign n_recent     = {r_recent[7:0], r_in_data};

    always_comb begin
        w_png_step.adv  = w_fire;
        w_png_step.upd  = (r_fmt == icic_pkg::FMT_PNG);
        w_png_step.last = r_in_last;
        w_png_step.data = r_in_data;
        w_hdr_step      = w_png_step;
        case (r_fmt)
            icic_pkg::FMT_JPEG, icic_pkg::FMT_GIF, icic_pkg::FMT_WEBP: w_hdr_step.upd = 1'b1;
            default: w_hdr_step.upd = 1'b0;
        endcase
    end

    icic_png_tracker u_png (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_png_step),
        .o_status (w_png_st)
    );

    icic_hdr_tracker u_hdr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_hdr_step),
        .i_fmt    (r_fmt),
        .i_pos    (r_byte_count),
        .o_status (w_hdr_st)
    );

    always_comb begin
        case (r_fmt)
            icic_pkg::FMT_PNG:
                w_ok = !w_png_st.failed && w_png_st.seen_iend;
            icic_pkg::FMT_JPEG:
                w_ok = (n_byte_count >= icic_pkg::CNT_W'(4)) && w_hdr_st.header_match[0] &&
                       (n_recent == icic_pkg::JPEG_EOI);
            icic_pkg::FMT_GIF:
                w_ok = (n_byte_count >= icic_pkg::CNT_W'(7)) && (w_hdr_st.header_match != 2'b00) &&
                       (r_in_data == icic_pkg::GIF_TRAIL);
            icic_pkg::FMT_WEBP:
                w_ok = (n_byte_count >= icic_pkg::CNT_W'(12)) &&
                       (w_hdr_st.header_match == 2'b11) &&
                       (icic_pkg::CMP_W'({1'b0, w_hdr_st.riff_size} + 33'd8) ==
                        icic_pkg::CMP_W'(n_byte_count));
            default:
                w_ok = 1'b1;
        endcase
        if (n_byte_count == icic_pkg::CNT_MAX) w_ok = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= icic_pkg::FMT_PNG;
        end else if (i_cfg_wr_en) begin
            r_fmt <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_data <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_fire && r_in_last)) begin
            r_byte_count <= '0;
            r_recent     <= '0;
        end else if (w_fire) begin
            r_byte_count <= n_byte_count;
            r_recent     <= n_recent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_last) begin
            r_out_intact <= w_ok;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_intact};

    `ASSERT_RST(a_last_held, i_clk, i_rst_n,
        (r_in_valid && r_in_last && !w_out_free |=> r_in_valid && r_in_last),
        "final byte dropped while verdict register busy")
    `ASSERT_RST(a_cnt_clear, i_clk, i_rst_n,
        (w_fire && r_in_last |=> r_byte_count == '0 && r_out_valid),
        "byte count not cleared or verdict missing after final byte")
    `ASSERT_RST(a_cnt_step, i_clk, i_rst_n,
        (w_fire && !r_in_last && r_byte_count != icic_pkg::CNT_MAX |=>
            r_byte_count == $past(r_byte_count) + icic_pkg::CNT_W'(1)),
        "byte count did not advance by one")

endmodule

// ----- tb/image_container_integrity_check_core_tb.sv -----
`timescale 1ns / 100ps

module image_container_integrity_check_core_tb;

    localparam logic [2:0] FMT_OTHER = 3'd4;
    localparam logic [2:0] FMT_RSVD5 = 3'd5;
    localparam logic [2:0] FMT_RSVD7 = 3'd7;

    // magic strings, byte k at [8*(N-1-k) +: 8]
    localparam logic [63:0] PNG_MAGIC  = 64'h89504e470d0a1a0a;
    localparam logic [47:0] GIF_MAGIC  = 48'h474946380061;
    localparam logic [31:0] RIFF_MAGIC = 32'h52494646;
    localparam logic [31:0] WEBP_MAGIC = 32'h57454250;

    localparam int ITEM_TARGET = 2000;
    localparam int HOLD_CYCLES = 500;
    localparam int CYCLE_LIMIT = 200000;

    class verdict_scoreboard;
        logic [2:0]                 fmt;
        logic [icic_pkg::CNT_W-1:0] byte_cnt;
        logic [31:0]                crc, chunk_len, chunk_pos, tag, crc_shift, riff_len;
        icic_pkg::t_png_phase       phase;
        bit                         seen_idat, seen_iend, failed;
        logic [15:0]                recent;
        logic [1:0]                 hdr;
        bit                         verdicts[$];
        int                         mismatches;

        function new();
            fmt = icic_pkg::FMT_PNG;
            mismatches = 0;
            clear();
        endfunction

        static function logic [31:0] crc_step(logic [31:0] c_in, logic [7:0] b);
            logic [31:0] c;
            c = c_in ^ {24'd0, b};
            for (int k = 0; k < 8; k++)
                c = (c >> 1) ^ (icic_pkg::CRC_POLY & {32{c[0]}});
            return c;
        endfunction

        function void clear();
            byte_cnt = '0;
            crc = icic_pkg::CRC_INIT;
            chunk_len = 0;
            chunk_pos = 0;
            tag = 0;
            crc_shift = 0;
            phase = icic_pkg::PH_SIG;
            seen_idat = 0;
            seen_iend = 0;
            failed = 0;
            recent = 0;
            hdr = 2'b11;
            riff_len = 0;
        endfunction

        function void png_byte(logic [7:0] b);
            case (phase)
                icic_pkg::PH_SIG: begin
                    if (b != PNG_MAGIC[8*(7-int'(chunk_pos[2:0])) +: 8]) failed = 1;
                    chunk_pos++;
                    if (chunk_pos >= 8) begin
                        phase = icic_pkg::PH_LEN;
                        chunk_pos = 0;
                        chunk_len = 0;
                    end
                end
                icic_pkg::PH_LEN: begin
                    chunk_len = {chunk_len[23:0], b};
                    chunk_pos++;
                    if (chunk_pos >= 4) begin
                        phase = icic_pkg::PH_TYPE;
                        chunk_pos = 0;
                        crc = icic_pkg::CRC_INIT;
                        tag = 0;
                    end
                end
                icic_pkg::PH_TYPE: begin
                    crc = crc_step(crc, b);
                    tag = {tag[23:0], b};
                    chunk_pos++;
                    if (chunk_pos >= 4) begin
                        chunk_pos = 0;
                        crc_shift = 0;
                        if (chunk_len != 0) phase = icic_pkg::PH_DATA;
                        else phase = icic_pkg::PH_CRC;
                    end
                end
                icic_pkg::PH_DATA: begin
                    crc = crc_step(crc, b);
                    chunk_pos++;
                    if (chunk_pos >= chunk_len) begin
                        phase = icic_pkg::PH_CRC;
                        chunk_pos = 0;
                    end
                end
                icic_pkg::PH_CRC: begin
                    crc_shift = {crc_shift[23:0], b};
                    chunk_pos++;
                    if (chunk_pos >= 4) begin
                        chunk_pos = 0;
                        phase = icic_pkg::PH_LEN;
                        if (crc_shift != ~crc) begin
                            failed = 1;
                        end else begin
                            if (tag == icic_pkg::TAG_IDAT) seen_idat = 1;
                            if (tag == icic_pkg::TAG_IEND) begin
                                if (chunk_len == 0 && seen_idat) begin
                                    seen_iend = 1;
                                    phase = icic_pkg::PH_DONE;
                                end else begin
                                    failed = 1;
                                end
                            end else begin
                                chunk_len = 0;
                            end
                        end
                    end
                end
                default: failed = 1;
            endcase
        endfunction

        function void header_byte(logic [7:0] b, logic [icic_pkg::CNT_W-1:0] pos);
            int p;
            p = (pos < 16) ? int'(pos) : 16;
            case (fmt)
                icic_pkg::FMT_JPEG: begin
                    if ((p == 0 && b != 8'hff) || (p == 1 && b != icic_pkg::JPEG_SOI1))
                        hdr &= 2'b10;
                end
                icic_pkg::FMT_GIF: begin
                    if (p == 4) begin
                        if (b != 8'h37) hdr &= 2'b10;
                        if (b != 8'h39) hdr &= 2'b01;
                    end else if (p < 6 && b != GIF_MAGIC[8*(5-p) +: 8]) begin
                        hdr = 2'b00;
                    end
                end
                icic_pkg::FMT_WEBP: begin
                    if (p < 4) begin
                        if (b != RIFF_MAGIC[8*(3-p) +: 8]) hdr &= 2'b10;
                    end else if (p < 8) begin
                        riff_len |= {24'd0, b} << (8*(p-4));
                    end else if (p < 12) begin
                        if (b != WEBP_MAGIC[8*(11-p) +: 8]) hdr &= 2'b01;
                    end
                end
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic l);
            logic [icic_pkg::CNT_W-1:0] pos;
            bit ok;
            pos = byte_cnt;
            if (byte_cnt != icic_pkg::CNT_MAX) byte_cnt++;
            recent = {recent[7:0], b};
            if (fmt == icic_pkg::FMT_PNG) png_byte(b);
            else header_byte(b, pos);
            if (!l) return;
            case (fmt)
                icic_pkg::FMT_PNG:  ok = !failed && seen_iend;
                icic_pkg::FMT_JPEG: ok = byte_cnt >= 4 && hdr[0] && recent == icic_pkg::JPEG_EOI;
                icic_pkg::FMT_GIF:  ok = byte_cnt >= 7 && hdr != 2'b00 &&
                                         b == icic_pkg::GIF_TRAIL;
                icic_pkg::FMT_WEBP: ok = byte_cnt >= 12 && hdr == 2'b11 &&
                                         (64'(riff_len) + 64'd8 == 64'(byte_cnt));
                default:            ok = 1;
            endcase
            if (byte_cnt == icic_pkg::CNT_MAX) ok = 0;
            verdicts.push_back(ok);
            clear();
        endfunction

        function void check_verdict(logic [7:0] got);
            bit want;
            if (verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected verdict transfer: %0h", got);
                return;
            end
            want = verdicts.pop_front();
            if (got !== {7'd0, want}) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("verdict mismatch: expected %0h, got %0h", {7'd0, want}, got);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [2:0] i_cfg_wr_data;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;
    logic       i_s_tlast;
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;

    verdict_scoreboard sb = new();
    logic [7:0] file_q[$];
    int  items_sent = 0;
    int  cycles = 0;
    bit  calm = 0;
    bit  hold_go = 0;

    image_container_integrity_check_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_verdict(o_m_tdata);
    end

    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_go = 0;
            end
            i_m_tready <= calm || ($urandom_range(0, 99) >= 17);
        end
    end

    function automatic void push_chunk(logic [31:0] ctag, logic [31:0] len);
        logic [31:0] c;
        logic [7:0]  d;
        c = icic_pkg::CRC_INIT;
        for (int i = 3; i >= 0; i--) file_q.push_back(len[8*i +: 8]);
        for (int i = 3; i >= 0; i--) begin
            file_q.push_back(ctag[8*i +: 8]);
            c = verdict_scoreboard::crc_step(c, ctag[8*i +: 8]);
        end
        for (int i = 0; i < int'(len); i++) begin
            d = 8'($urandom);
            file_q.push_back(d);
            c = verdict_scoreboard::crc_step(c, d);
        end
        c = ~c;
        for (int i = 3; i >= 0; i--) file_q.push_back(c[8*i +: 8]);
    endfunction

    function automatic void build_file(logic [2:0] f);
        int n;
        file_q = {};
        case (f)
            icic_pkg::FMT_PNG: begin
                for (int k = 0; k < 8; k++) file_q.push_back(PNG_MAGIC[8*(7-k) +: 8]);
                repeat ($urandom_range(0, 2)) push_chunk($urandom, $urandom_range(0, 12));
                if ($urandom_range(0, 11) != 0)
                    push_chunk(icic_pkg::TAG_IDAT, $urandom_range(0, 20));
                if ($urandom_range(0, 3) == 0)
                    push_chunk(icic_pkg::TAG_IDAT, $urandom_range(0, 8));
                if ($urandom_range(0, 3) == 0) push_chunk($urandom, $urandom_range(0, 6));
                if ($urandom_range(0, 15) == 0)
                    push_chunk(icic_pkg::TAG_IEND, $urandom_range(1, 4));
                else push_chunk(icic_pkg::TAG_IEND, 0);
            end
            icic_pkg::FMT_JPEG: begin
                file_q.push_back(8'hff);
                file_q.push_back(icic_pkg::JPEG_SOI1);
                repeat ($urandom_range(0, 24)) file_q.push_back(8'($urandom));
                file_q.push_back(icic_pkg::JPEG_EOI[15:8]);
                file_q.push_back(icic_pkg::JPEG_EOI[7:0]);
            end
            icic_pkg::FMT_GIF: begin
                for (int k = 0; k < 6; k++) begin
                    if (k == 4) file_q.push_back($urandom_range(0, 1) ? 8'h39 : 8'h37);
                    else file_q.push_back(GIF_MAGIC[8*(5-k) +: 8]);
                end
                repeat ($urandom_range(0, 20)) file_q.push_back(8'($urandom));
                file_q.push_back(icic_pkg::GIF_TRAIL);
            end
            icic_pkg::FMT_WEBP: begin
                n = $urandom_range(0, 20);
                for (int k = 0; k < 4; k++) file_q.push_back(RIFF_MAGIC[8*(3-k) +: 8]);
                for (int k = 0; k < 4; k++) file_q.push_back(8'((n + 4) >> (8*k)));
                for (int k = 0; k < 4; k++) file_q.push_back(WEBP_MAGIC[8*(3-k) +: 8]);
                repeat (n) file_q.push_back(8'($urandom));
            end
            default: repeat ($urandom_range(1, 24)) file_q.push_back(8'($urandom));
        endcase
        // damage about one file in three
        case ($urandom_range(0, 11))
            0: begin
                n = $urandom_range(0, file_q.size() - 1);
                file_q[n] ^= 8'd1 << $urandom_range(0, 7);
            end
            1: begin
                n = $urandom_range(1, file_q.size());
                while (file_q.size() > n) void'(file_q.pop_back());
            end
            2: repeat ($urandom_range(1, 4)) file_q.push_back(8'($urandom));
            3: begin
                file_q = {};
                repeat ($urandom_range(1, 24)) file_q.push_back(8'($urandom));
            end
            default: ;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic l);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 17) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tlast  <= l;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_byte(d, l);
        items_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.verdicts.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic switch_format(input logic [2:0] f);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= f;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.fmt = f;
    endtask

    initial begin
        logic [2:0] f;
        int         phase_idx;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tlast     = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: minimal valid files, one-byte files, pass-through codes
        switch_format(icic_pkg::FMT_JPEG);
        file_q = '{8'hff, 8'hd8, 8'hff, 8'hd9};
        send_file();
        file_q = '{8'hff};
        send_file();
        switch_format(icic_pkg::FMT_GIF);
        file_q = '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h3b};
        send_file();
        switch_format(icic_pkg::FMT_WEBP);
        file_q = '{8'h52, 8'h49, 8'h46, 8'h46, 8'h04, 8'h00, 8'h00, 8'h00,
                   8'h57, 8'h45, 8'h42, 8'h50};
        send_file();
        switch_format(FMT_OTHER);
        file_q = '{8'h00};
        send_file();
        switch_format(FMT_RSVD7);
        file_q = '{8'hff};
        send_file();

        phase_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: f = icic_pkg::FMT_PNG;
                4:          f = icic_pkg::FMT_JPEG;
                5:          f = icic_pkg::FMT_GIF;
                6:          f = icic_pkg::FMT_WEBP;
                7:          f = FMT_OTHER;
                default:    f = 3'($urandom_range(FMT_RSVD5, FMT_RSVD7));
            endcase
            if (phase_idx == 0) f = icic_pkg::FMT_PNG;
            switch_format(f);
            calm = (phase_idx == 2);
            if (phase_idx == 4) hold_go = 1;
            repeat ($urandom_range(4, 12)) begin
                build_file(f);
                send_file();
            end
            phase_idx++;
        end
        calm = 0;

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.verdicts.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/icic_pkg.sv
hw/rtl/icic_png_tracker.sv
hw/rtl/icic_hdr_tracker.sv
hw/rtl/image_container_integrity_check_core.sv
tb/image_container_integrity_check_core_tb.sv
